// ===== rtl/core/mf3x3_pkg.sv =====
// Shared types and constants for the 3x3 median filter core.
// Item structs for the sample and result channels, window tag, output queue sizing.
// No dependencies.
package mf3x3_pkg;

    localparam int ROW_BITS = 10;
    localparam logic [ROW_BITS-1:0] ROW_MAX = 10'd1023;

    localparam int CFG_BITS = 11;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET = 11'd640;

    // output queue; must cover every emitting item in flight plus those waiting
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } sample_t;

    typedef struct packed {
        logic [7:0]  median_value;
        logic [9:0]  center_row;
        logic [9:0]  center_col;
    } result_t;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
    } center_tag_t;

endpackage

// ===== rtl/core/mf3x3_line_mem.sv =====
// Line buffer memory: one entry per column holds {upper row, middle row} pixels.
// Simple dual port, registered read data. No package use.
module mf3x3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mf3x3_median.sv =====
// Two-stage compare-exchange network selecting the median of a 3x3 window.
// Uses mf3x3_pkg::center_tag_t to carry the window center alongside.
module mf3x3_median #(
    parameter int PW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [8:0][PW-1:0]    window,
    input  mf3x3_pkg::center_tag_t in_tag,
    output logic                  out_valid,
    output logic [PW-1:0]         out_median,
    output mf3x3_pkg::center_tag_t out_tag
);

    typedef logic [8:0][PW-1:0] win_t;

    function automatic win_t cx(input win_t v, input int a, input int b);
        win_t r;
        r = v;
        if (v[a] > v[b])
        begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    win_t                   sorted_rows;
    win_t                   tail;
    win_t                   rows_reg;
    logic                   a_valid_reg;
    mf3x3_pkg::center_tag_t a_tag_reg;
    logic                   b_valid_reg;
    logic [PW-1:0]          b_median_reg;
    mf3x3_pkg::center_tag_t b_tag_reg;

    // stage A: sort each row of three
    always_comb
    begin
        sorted_rows = window;
        sorted_rows = cx(sorted_rows, 1, 2);
        sorted_rows = cx(sorted_rows, 4, 5);
        sorted_rows = cx(sorted_rows, 7, 8);
        sorted_rows = cx(sorted_rows, 0, 1);
        sorted_rows = cx(sorted_rows, 3, 4);
        sorted_rows = cx(sorted_rows, 6, 7);
        sorted_rows = cx(sorted_rows, 1, 2);
        sorted_rows = cx(sorted_rows, 4, 5);
        sorted_rows = cx(sorted_rows, 7, 8);
    end

    // stage B: column pruning down to the center element
    always_comb
    begin
        tail = rows_reg;
        tail = cx(tail, 0, 3);
        tail = cx(tail, 5, 8);
        tail = cx(tail, 4, 7);
        tail = cx(tail, 3, 6);
        tail = cx(tail, 1, 4);
        tail = cx(tail, 2, 5);
        tail = cx(tail, 4, 7);
        tail = cx(tail, 4, 2);
        tail = cx(tail, 6, 4);
        tail = cx(tail, 4, 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg     <= sorted_rows;
        a_tag_reg    <= in_tag;
        b_median_reg <= tail[4];
        b_tag_reg    <= a_tag_reg;
    end

    assign out_valid  = b_valid_reg;
    assign out_median = b_median_reg;
    assign out_tag    = b_tag_reg;

endmodule

// ===== rtl/core/mf3x3_out_fifo.sv =====
// Result queue between the filter pipeline and the result channel.
// Depends on mf3x3_pkg for result_t and queue sizing.
module mf3x3_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mf3x3_pkg::result_t push_item,
    input  logic               pop,
    output logic               valid,
    output mf3x3_pkg::result_t head
);

    mf3x3_pkg::result_t                      store [mf3x3_pkg::OUT_DEPTH];
    logic [mf3x3_pkg::OUT_PTR_W-1:0]         wr_ptr_reg;
    logic [mf3x3_pkg::OUT_PTR_W-1:0]         rd_ptr_reg;
    logic [mf3x3_pkg::OUT_CNT_W-1:0]         count_reg;
    logic [mf3x3_pkg::OUT_CNT_W-1:0]         count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = store[rd_ptr_reg];

endmodule

// ===== rtl/core/median_filter_3x3_core.sv =====
// Streaming 3x3 median filter top level: counters, line buffer read-modify-write,
// window registers. Depends on mf3x3_pkg, mf3x3_line_mem, mf3x3_median, mf3x3_out_fifo.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  sample   | sample_valid/sample_stall | sample  (pixel, frame_start)
//  result   | result_valid/result_stall | result  (median, center row/col)
//  cfg      | cfg_valid/cfg_ready       | cfg_data (image width)
//
// One item per cycle while sample_stall is low; result_valid rises once its item has
// passed the S1 registers, both median stages and the output queue. The line buffer is
// read at accept and written back in the next cycle; a read of the column being written
// back in that same cycle is forwarded. sample_stall rises when 8 emitting items are in
// flight or queued, so a stalled result side cannot overflow the queue. Reset sets width to 640.
module median_filter_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  mf3x3_pkg::sample_t                sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output mf3x3_pkg::result_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mf3x3_pkg::CFG_BITS-1:0]    cfg_data
);

    localparam int PW = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > mf3x3_pkg::CFG_BITS + 1) ? CW + 1 : mf3x3_pkg::CFG_BITS + 1;
    localparam int RW = mf3x3_pkg::ROW_BITS;

    logic [mf3x3_pkg::CFG_BITS-1:0] width_reg;
    logic [WW-1:0]                  width_eff;
    logic [RW-1:0]                  row_reg;
    logic [RW-1:0]                  row_next;
    logic [CW-1:0]                  col_reg;
    logic [CW-1:0]                  col_next;
    logic [RW-1:0]                  row_cur;
    logic [CW-1:0]                  col_cur;
    logic [RW-1:0]                  row_m1;
    logic [CW-1:0]                  col_m1;
    logic [WW-1:0]                  col_p1;
    logic                           accept;
    logic                           emit;

    logic                           s1_valid_reg;
    logic                           s1_emit_reg;
    logic [CW-1:0]                  s1_addr_reg;
    logic [PW-1:0]                  s1_px_reg;
    mf3x3_pkg::center_tag_t         s1_tag_reg;
    logic                           s1_fwd_reg;
    logic [2*PW-1:0]                s1_fwd_data_reg;

    logic [2*PW-1:0]                mem_rd_data;
    logic [2*PW-1:0]                line_word;
    logic [2*PW-1:0]                wr_word;

    logic [8:0][PW-1:0]             window_reg;
    logic [8:0][PW-1:0]             window_next;

    logic                           med_valid;
    logic [PW-1:0]                  med_value;
    mf3x3_pkg::center_tag_t         med_tag;
    mf3x3_pkg::result_t             push_item;
    logic                           out_pop;

    logic [mf3x3_pkg::OUT_CNT_W-1:0] credit_reg;
    logic [mf3x3_pkg::OUT_CNT_W-1:0] credit_next;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (credit_reg == mf3x3_pkg::OUT_CNT_W'(mf3x3_pkg::OUT_DEPTH));
    assign accept       = sample_valid && !sample_stall;

    // width clamp to 3..MAX_WIDTH
    always_comb
    begin
        width_eff = WW'(width_reg);
        if (width_eff < WW'(3))
        begin
            width_eff = WW'(3);
        end
        else if (width_eff > WW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
    end

    always_comb
    begin
        row_cur  = sample.frame_start ? '0 : row_reg;
        col_cur  = sample.frame_start ? '0 : col_reg;
        emit     = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
        row_m1   = row_cur - 1'b1;
        col_m1   = col_cur - 1'b1;
        col_p1   = WW'(col_cur) + 1'b1;
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_p1 >= width_eff)
            begin
                col_next = '0;
                row_next = (row_cur < mf3x3_pkg::ROW_MAX) ? row_cur + 1'b1 : row_cur;
            end
            else
            begin
                col_next = CW'(col_p1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mf3x3_pkg::WIDTH_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            credit_reg   <= '0;
            window_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= accept;
            credit_reg   <= credit_next;
            window_reg   <= window_next;
        end
    end

    // item in S1 writes its column while the next item reads; catch the overlap
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg     <= emit;
            s1_addr_reg     <= col_cur;
            s1_px_reg       <= sample.pixel[PW-1:0];
            s1_tag_reg.row  <= row_m1;
            s1_tag_reg.col  <= 10'(col_m1);
            s1_fwd_reg      <= s1_valid_reg && (s1_addr_reg == col_cur);
            s1_fwd_data_reg <= wr_word;
        end
    end

    mf3x3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (mem_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word)
    );

    // entry layout: upper row in the high half, middle row in the low half
    assign line_word = s1_fwd_reg ? s1_fwd_data_reg : mem_rd_data;
    assign wr_word   = {line_word[PW-1:0], s1_px_reg};

    always_comb
    begin
        window_next = window_reg;
        if (s1_valid_reg)
        begin
            window_next[0] = window_reg[1];
            window_next[1] = window_reg[2];
            window_next[2] = line_word[2*PW-1:PW];
            window_next[3] = window_reg[4];
            window_next[4] = window_reg[5];
            window_next[5] = line_word[PW-1:0];
            window_next[6] = window_reg[7];
            window_next[7] = window_reg[8];
            window_next[8] = s1_px_reg;
        end
    end

    mf3x3_median #(
        .PW (PW)
    ) u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg && s1_emit_reg),
        .window     (window_next),
        .in_tag     (s1_tag_reg),
        .out_valid  (med_valid),
        .out_median (med_value),
        .out_tag    (med_tag)
    );

    always_comb
    begin
        push_item.median_value = 8'(med_value);
        push_item.center_row   = med_tag.row;
        push_item.center_col   = med_tag.col;
    end

    assign out_pop = result_valid && !result_stall;

    // one credit per emitting item from accept until its result is taken
    always_comb
    begin
        credit_next = credit_reg;
        if ((accept && emit) && !out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_pop && !(accept && emit))
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    mf3x3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (med_valid),
        .push_item (push_item),
        .pop       (out_pop),
        .valid     (result_valid),
        .head      (result)
    );

endmodule
